FILE: rtl/core/kpes_pkg.sv
// kpes_pkg: shared types, constants and the key map of the keypad PIN entry scanner
// no dependencies; used by keypad_pin_entry_scanner, kpes_scan_checker and the testbench

package kpes_pkg;

   // number of digits that make up one entry
   localparam int unsigned CODE_DIGITS = 4;

   // field widths
   localparam int unsigned ROW_W    = 2;
   localparam int unsigned COL_W    = 2;
   localparam int unsigned LINES_W  = 4;
   localparam int unsigned DIGIT_W  = 4;
   localparam int unsigned CODE_W   = 14;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned TAKEN_W  = 3;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // reset values of the registers
   localparam logic [CODE_W-1:0]  PIN_RESET    = CODE_W'(5678);
   localparam logic [COUNT_W-1:0] SETTLE_RESET = COUNT_W'(50);

   // all columns high, or all rows released
   localparam logic [LINES_W-1:0] ALL_HIGH = '1;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_PIN_CODE     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_TICKS = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      PH_SCAN           = 2'd0,
      PH_PRESS_SETTLE   = 2'd1,
      PH_WAIT_RELEASE   = 2'd2,
      PH_RELEASE_SETTLE = 2'd3
   } phase_type;

   // key index row*4+col to digit, keys without a digit give 0
   function automatic logic [DIGIT_W-1:0] key_to_digit(input logic [ROW_W+COL_W-1:0] key);
      logic [DIGIT_W-1:0] digit;
      if (key <= (ROW_W+COL_W)'(9)) begin
         digit = DIGIT_W'(key);
      end else begin
         digit = '0;
      end
      return digit;
   endfunction

   // active-low drive pattern for one row
   function automatic logic [LINES_W-1:0] drive_row(input logic [ROW_W-1:0] row);
      logic [LINES_W-1:0] lines;
      lines = ALL_HIGH;
      lines[row] = 1'b0;
      return lines;
   endfunction

endpackage

FILE: rtl/core/keypad_pin_entry_scanner.sv
// keypad_pin_entry_scanner: 4x4 key matrix scanner with debounce and PIN compare
// depends on kpes_pkg

// One request is one sampling tick of the four column lines; each request gives
// exactly one response, registered when the request is taken. A new request is
// taken in every cycle while the response register is empty or being drained,
// so the sustained rate is one tick per cycle, set by the single pass of
// scan/debounce logic between the request port and the response register.
// Rows are driven low one at a time; the lowest low column wins. After a press
// the block waits settle_ticks, waits for all columns high, waits settle_ticks
// again, then releases all rows and reports the digit. Every fourth digit
// completes an entry whose decimal code is compared with pin_code. Register
// writes (index 0 pin_code, index 1 settle_ticks, others ignored) are always
// taken and should only be made while the block is idle.

module keypad_pin_entry_scanner (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [kpes_pkg::LINES_W-1:0]        req_col_levels,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [kpes_pkg::LINES_W-1:0]        rsp_row_lines,
   output logic                                rsp_key_valid,
   output logic [kpes_pkg::DIGIT_W-1:0]        rsp_key_digit,
   output logic                                rsp_entry_done,
   output logic [kpes_pkg::CODE_W-1:0]         rsp_entered_code,
   output logic                                rsp_code_match,
   // configuration channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kpes_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [kpes_pkg::CSR_DATA_W-1:0]     csr_data
);

   // configuration registers
   logic [kpes_pkg::CODE_W-1:0]  pin_code_ff;
   logic [kpes_pkg::COUNT_W-1:0] settle_ticks_ff;

   // scanner state
   kpes_pkg::phase_type          phase_ff, phase_in;
   logic [kpes_pkg::ROW_W-1:0]   scan_row_ff, scan_row_in;
   logic [kpes_pkg::COUNT_W-1:0] settle_count_ff, settle_count_in;
   logic [kpes_pkg::ROW_W-1:0]   held_row_ff, held_row_in;
   logic [kpes_pkg::COL_W-1:0]   held_col_ff, held_col_in;
   logic [kpes_pkg::TAKEN_W-1:0] digits_taken_ff, digits_taken_in;
   logic [kpes_pkg::CODE_W-1:0]  code_so_far_ff, code_so_far_in;

   // response register
   logic                         rsp_valid_ff;
   logic [kpes_pkg::LINES_W-1:0] rows_ff, rows_in;
   logic                         kvalid_ff, kvalid_in;
   logic [kpes_pkg::DIGIT_W-1:0] kdigit_ff, kdigit_in;
   logic                         done_ff, done_in;
   logic [kpes_pkg::CODE_W-1:0]  code_ff, code_in;
   logic                         match_ff, match_in;

   logic                         req_take;
   logic                         cols_idle;
   logic                         settled;
   logic [kpes_pkg::COL_W-1:0]   press_col;
   logic [kpes_pkg::DIGIT_W-1:0] digit;
   logic [kpes_pkg::CODE_W+3:0]  code_next;
   logic [kpes_pkg::TAKEN_W-1:0] taken_next;

   // handshakes
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pin_code_ff     <= kpes_pkg::PIN_RESET;
         settle_ticks_ff <= kpes_pkg::SETTLE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            kpes_pkg::CSR_PIN_CODE:     pin_code_ff     <= csr_data[kpes_pkg::CODE_W-1:0];
            kpes_pkg::CSR_SETTLE_TICKS: settle_ticks_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // column priority, lowest low column wins
   always_comb begin
      if (!req_col_levels[0]) begin
         press_col = kpes_pkg::COL_W'(0);
      end else if (!req_col_levels[1]) begin
         press_col = kpes_pkg::COL_W'(1);
      end else if (!req_col_levels[2]) begin
         press_col = kpes_pkg::COL_W'(2);
      end else begin
         press_col = kpes_pkg::COL_W'(3);
      end
   end

   assign cols_idle  = (req_col_levels == kpes_pkg::ALL_HIGH);
   assign settled    = (settle_count_ff >= settle_ticks_ff);
   assign digit      = kpes_pkg::key_to_digit({held_row_ff, held_col_ff});
   // code * 10 + digit as two shifts and adds
   assign code_next  = ({4'b0, code_so_far_ff} << 3) + ({4'b0, code_so_far_ff} << 1)
                       + (kpes_pkg::CODE_W+4)'(digit);
   assign taken_next = digits_taken_ff + kpes_pkg::TAKEN_W'(1);

   // next state and response
   always_comb begin
      phase_in        = phase_ff;
      scan_row_in     = scan_row_ff;
      settle_count_in = settle_count_ff;
      held_row_in     = held_row_ff;
      held_col_in     = held_col_ff;
      digits_taken_in = digits_taken_ff;
      code_so_far_in  = code_so_far_ff;
      rows_in         = kpes_pkg::ALL_HIGH;
      kvalid_in       = 1'b0;
      kdigit_in       = '0;
      done_in         = 1'b0;
      code_in         = '0;
      match_in        = 1'b0;

      unique case (phase_ff)
         kpes_pkg::PH_SCAN: begin
            rows_in = kpes_pkg::drive_row(scan_row_ff);
            if (!cols_idle) begin
               held_row_in     = scan_row_ff;
               held_col_in     = press_col;
               settle_count_in = '0;
               phase_in        = kpes_pkg::PH_PRESS_SETTLE;
            end else begin
               scan_row_in = scan_row_ff + kpes_pkg::ROW_W'(1);
            end
         end
         kpes_pkg::PH_PRESS_SETTLE: begin
            rows_in = kpes_pkg::drive_row(held_row_ff);
            if (settled) begin
               // settle done, release check on the same tick
               phase_in = kpes_pkg::PH_WAIT_RELEASE;
               if (cols_idle) begin
                  settle_count_in = '0;
                  phase_in        = kpes_pkg::PH_RELEASE_SETTLE;
               end
            end else begin
               settle_count_in = settle_count_ff + kpes_pkg::COUNT_W'(1);
            end
         end
         kpes_pkg::PH_WAIT_RELEASE: begin
            rows_in = kpes_pkg::drive_row(held_row_ff);
            if (cols_idle) begin
               settle_count_in = '0;
               phase_in        = kpes_pkg::PH_RELEASE_SETTLE;
            end
         end
         kpes_pkg::PH_RELEASE_SETTLE: begin
            if (settled) begin
               // accept the digit and restart scanning
               kvalid_in   = 1'b1;
               kdigit_in   = digit;
               scan_row_in = '0;
               phase_in    = kpes_pkg::PH_SCAN;
               if (taken_next >= kpes_pkg::TAKEN_W'(kpes_pkg::CODE_DIGITS)) begin
                  done_in         = 1'b1;
                  code_in         = code_next[kpes_pkg::CODE_W-1:0];
                  match_in        = (code_next[kpes_pkg::CODE_W-1:0] == pin_code_ff);
                  code_so_far_in  = '0;
                  digits_taken_in = '0;
               end else begin
                  code_so_far_in  = code_next[kpes_pkg::CODE_W-1:0];
                  digits_taken_in = taken_next;
               end
            end else begin
               rows_in         = kpes_pkg::drive_row(held_row_ff);
               settle_count_in = settle_count_ff + kpes_pkg::COUNT_W'(1);
            end
         end
         default: ;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= kpes_pkg::PH_SCAN;
         scan_row_ff     <= '0;
         settle_count_ff <= '0;
         held_row_ff     <= '0;
         held_col_ff     <= '0;
         digits_taken_ff <= '0;
         code_so_far_ff  <= '0;
      end else if (req_take) begin
         phase_ff        <= phase_in;
         scan_row_ff     <= scan_row_in;
         settle_count_ff <= settle_count_in;
         held_row_ff     <= held_row_in;
         held_col_ff     <= held_col_in;
         digits_taken_ff <= digits_taken_in;
         code_so_far_ff  <= code_so_far_in;
      end
   end

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         rows_ff   <= rows_in;
         kvalid_ff <= kvalid_in;
         kdigit_ff <= kdigit_in;
         done_ff   <= done_in;
         code_ff   <= code_in;
         match_ff  <= match_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_row_lines    = rows_ff;
   assign rsp_key_valid    = kvalid_ff;
   assign rsp_key_digit    = kdigit_ff;
   assign rsp_entry_done   = done_ff;
   assign rsp_entered_code = code_ff;
   assign rsp_code_match   = match_ff;

endmodule

FILE: tb/kpes_scan_checker.sv
// kpes_scan_checker: watches the request, response and register channels of the keypad
// scanner, predicts every response and compares it field by field; depends on kpes_pkg

module kpes_scan_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [kpes_pkg::LINES_W-1:0]      req_col_levels,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [kpes_pkg::LINES_W-1:0]      rsp_row_lines,
   input  logic                              rsp_key_valid,
   input  logic [kpes_pkg::DIGIT_W-1:0]      rsp_key_digit,
   input  logic                              rsp_entry_done,
   input  logic [kpes_pkg::CODE_W-1:0]       rsp_entered_code,
   input  logic                              rsp_code_match,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [kpes_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kpes_pkg::CSR_DATA_W-1:0]   csr_data,
   output int                                mismatches,
   output int                                pending_count,
   output int                                entry_progress,
   output int                                digits_seen,
   output int                                entries_seen,
   output int                                matches_seen
);
   import kpes_pkg::*;

   typedef struct packed {
      logic [LINES_W-1:0] row_lines;
      logic               key_valid;
      logic [DIGIT_W-1:0] key_digit;
      logic               entry_done;
      logic [CODE_W-1:0]  entered_code;
      logic               code_match;
   } tick_outcome_type;

   // predicted scanner state and register copies
   phase_type           cur_phase;
   logic [ROW_W-1:0]    row_ptr;
   logic [COUNT_W-1:0]  wait_count;
   logic [ROW_W-1:0]    latched_row;
   logic [COL_W-1:0]    latched_col;
   logic [TAKEN_W-1:0]  digit_count;
   logic [CODE_W-1:0]   partial_code;
   logic [CODE_W-1:0]   pin_value;
   logic [COUNT_W-1:0]  settle_len;

   tick_outcome_type expected_ticks[$];

   function automatic logic [LINES_W-1:0] row_pattern(input logic [ROW_W-1:0] r);
      return ~(LINES_W'(1) << r);
   endfunction

   // one column sample through the scan / debounce / entry logic
   function automatic tick_outcome_type advance_scanner(input logic [LINES_W-1:0] cols);
      tick_outcome_type o;
      logic [ROW_W+COL_W-1:0] key;
      logic [DIGIT_W-1:0] digit;
      o = '0;
      o.row_lines = ALL_HIGH;
      case (cur_phase)
         PH_SCAN: begin
            o.row_lines = row_pattern(row_ptr);
            if (cols != ALL_HIGH) begin
               // lowest low column wins
               if (!cols[0]) latched_col = 2'd0;
               else if (!cols[1]) latched_col = 2'd1;
               else if (!cols[2]) latched_col = 2'd2;
               else latched_col = 2'd3;
               latched_row = row_ptr;
               wait_count = '0;
               cur_phase = PH_PRESS_SETTLE;
            end else begin
               row_ptr = row_ptr + 1'b1;
            end
         end
         PH_PRESS_SETTLE, PH_WAIT_RELEASE: begin
            o.row_lines = row_pattern(latched_row);
            if (cur_phase == PH_PRESS_SETTLE) begin
               if (wait_count >= settle_len) cur_phase = PH_WAIT_RELEASE;
               else wait_count = wait_count + 1'b1;
            end
            // finished press wait falls through to the release check on the same tick
            if (cur_phase == PH_WAIT_RELEASE && cols == ALL_HIGH) begin
               wait_count = '0;
               cur_phase = PH_RELEASE_SETTLE;
            end
         end
         default: begin
            if (wait_count >= settle_len) begin
               key = {latched_row, latched_col};
               digit = (key <= 4'd9) ? DIGIT_W'(key) : '0;
               o.key_valid = 1'b1;
               o.key_digit = digit;
               partial_code = CODE_W'(partial_code * 10 + digit);
               digit_count = digit_count + 1'b1;
               if (digit_count >= CODE_DIGITS) begin
                  o.entry_done = 1'b1;
                  o.entered_code = partial_code;
                  o.code_match = (partial_code == pin_value);
                  partial_code = '0;
                  digit_count = '0;
               end
               row_ptr = '0;
               cur_phase = PH_SCAN;
            end else begin
               o.row_lines = row_pattern(latched_row);
               wait_count = wait_count + 1'b1;
            end
         end
      endcase
      return o;
   endfunction

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   // sample all three channels at the rising edge
   always @(posedge clock) begin : watch
      tick_outcome_type want;
      if (reset) begin
         cur_phase = PH_SCAN;
         row_ptr = '0;
         wait_count = '0;
         latched_row = '0;
         latched_col = '0;
         digit_count = '0;
         partial_code = '0;
         pin_value = PIN_RESET;
         settle_len = SETTLE_RESET;
         expected_ticks.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PIN_CODE) pin_value = csr_data[CODE_W-1:0];
            else if (csr_index == CSR_SETTLE_TICKS) settle_len = csr_data;
         end
         if (req_valid && req_ready) expected_ticks.push_back(advance_scanner(req_col_levels));
         if (rsp_valid && rsp_ready) begin
            if (expected_ticks.size() == 0) begin
               $display("%0t: response with no request outstanding, expected none, got row_lines %0d",
                        $time, rsp_row_lines);
               mismatches++;
            end else begin
               want = expected_ticks.pop_front();
               check_field("row_lines", want.row_lines, rsp_row_lines);
               check_field("key_valid", want.key_valid, rsp_key_valid);
               check_field("key_digit", want.key_digit, rsp_key_digit);
               check_field("entry_done", want.entry_done, rsp_entry_done);
               check_field("entered_code", want.entered_code, rsp_entered_code);
               check_field("code_match", want.code_match, rsp_code_match);
               digits_seen += want.key_valid;
               entries_seen += want.entry_done;
               matches_seen += want.code_match;
            end
         end
      end
      pending_count = expected_ticks.size();
      entry_progress = digit_count;
   end

endmodule

FILE: tb/tb_keypad_pin_entry_scanner.sv
// tb_keypad_pin_entry_scanner: drives column samples and register writes into the scanner
// and gives the verdict; depends on kpes_pkg, kpes_scan_checker and the scanner RTL

module tb_keypad_pin_entry_scanner;
   import kpes_pkg::*;

   // indexes that the block ignores
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = CSR_IDX_W'(3);
   localparam int                   MAX_SETTLE  = 65535;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [LINES_W-1:0]     req_col_levels;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [LINES_W-1:0]     rsp_row_lines;
   logic                   rsp_key_valid;
   logic [DIGIT_W-1:0]     rsp_key_digit;
   logic                   rsp_entry_done;
   logic [CODE_W-1:0]      rsp_entered_code;
   logic                   rsp_code_match;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   int mismatches, pending_count, entry_progress;
   int digits_seen, entries_seen, matches_seen;

   int ticks_sent;
   int settle_now;
   bit steady_stretch;

   keypad_pin_entry_scanner uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_col_levels(req_col_levels),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_row_lines(rsp_row_lines),
      .rsp_key_valid(rsp_key_valid), .rsp_key_digit(rsp_key_digit),
      .rsp_entry_done(rsp_entry_done), .rsp_entered_code(rsp_entered_code),
      .rsp_code_match(rsp_code_match),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   kpes_scan_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_col_levels(req_col_levels),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_row_lines(rsp_row_lines),
      .rsp_key_valid(rsp_key_valid), .rsp_key_digit(rsp_key_digit),
      .rsp_entry_done(rsp_entry_done), .rsp_entered_code(rsp_entered_code),
      .rsp_code_match(rsp_code_match),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .mismatches(mismatches), .pending_count(pending_count),
      .entry_progress(entry_progress), .digits_seen(digits_seen),
      .entries_seen(entries_seen), .matches_seen(matches_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side stalls at random except in the steady stretch
   initial rsp_ready = 1'b0;
   always @(negedge clock) begin
      rsp_ready <= steady_stretch || ($urandom_range(0, 99) >= 22);
   end

   // one column sample request, entered and left at a falling edge
   task automatic send_tick(input logic [LINES_W-1:0] cols);
      while (!steady_stretch && $urandom_range(0, 99) < 22) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_col_levels <= cols;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ticks_sent++;
      @(negedge clock);
   endtask

   // hold requests back until every response has come
   task automatic drain_requests();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      drain_requests();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_SETTLE_TICKS) settle_now = value;
      @(negedge clock);
   endtask

   // full press and release of one key, starting and ending with the scan at row 0;
   // fill sets the column lines above the pressed one
   task automatic press_key(input int key, input logic [LINES_W-1:0] fill);
      int row, col, extra, release_ticks;
      logic [LINES_W-1:0] low_mask, pattern;
      row = key / 4;
      col = key % 4;
      low_mask = LINES_W'((1 << col) - 1);
      pattern = (fill | low_mask) & ~(LINES_W'(1) << col);
      extra = $urandom_range(0, (settle_now < 3) ? settle_now + 2 : 3);
      // extra lap of idle rows exercises the scan wrap
      repeat (row + 4 * $urandom_range(0, 1)) send_tick(ALL_HIGH);
      send_tick(pattern);
      repeat (extra) send_tick(LINES_W'($urandom_range(0, 14)));
      // press wait, release detect, release wait, accept
      release_ticks = ((settle_now > extra) ? settle_now : extra) + settle_now + 2 - extra;
      repeat (release_ticks) send_tick(ALL_HIGH);
   endtask

   // four keys, either spelling the pin or random
   task automatic key_in_entry(input int pin, input bit aim);
      int div, d, key;
      div = 1000;
      repeat (CODE_DIGITS) begin
         if (aim) begin
            d = (pin / div) % 10;
            key = d;
            if (d == 0 && $urandom_range(0, 1)) key = $urandom_range(10, 15);
         end else begin
            key = $urandom_range(0, 15);
         end
         press_key(key, LINES_W'($urandom_range(0, 15)));
         div = div / 10;
      end
   endtask

   // complete a partial entry so that the next one starts at its first digit
   task automatic finish_entry();
      drain_requests();
      repeat ((CODE_DIGITS - entry_progress) % CODE_DIGITS)
         press_key($urandom_range(0, 15), LINES_W'($urandom_range(0, 15)));
   endtask

   // random column noise, then a forced press/release back to a known scan row
   task automatic noise_burst();
      repeat ($urandom_range(4, 24)) send_tick(LINES_W'($urandom_range(0, 15)));
      repeat (2 * settle_now + 3) send_tick(LINES_W'($urandom_range(0, 14)));
      repeat (settle_now + 2) send_tick(ALL_HIGH);
      finish_entry();
   endtask

   initial begin : stimulus
      int random_end, phase_end, phase_no, pin;
      reset = 1'b1;
      req_valid = 1'b0;
      req_col_levels = ALL_HIGH;
      csr_valid = 1'b0;
      csr_index = CSR_PIN_CODE;
      csr_data = '0;
      ticks_sent = 0;
      settle_now = SETTLE_RESET;
      steady_stretch = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values: default settle time and default pin
      press_key(5, 4'h0);
      press_key(6, 4'hF);
      press_key(7, 4'h0);
      press_key(8, 4'h5);

      // zero settle, pin 0 with the unused data bits set, keys without a digit
      write_register(CSR_SETTLE_TICKS, '0);
      write_register(CSR_PIN_CODE, 16'hC000);
      write_register(CSR_SPARE_A, 16'hFFFF);
      write_register(CSR_SPARE_B, 16'h1234);
      press_key(0, 4'h0);
      press_key(15, 4'h0);
      press_key(10, 4'hF);
      press_key(13, 4'h0);

      // longest settle time, shortened while the press wait and then the release wait run
      write_register(CSR_SETTLE_TICKS, CSR_DATA_W'(MAX_SETTLE));
      send_tick(ALL_HIGH);
      send_tick(ALL_HIGH);
      send_tick(4'b1101);
      repeat (20) send_tick(4'b1011);
      write_register(CSR_SETTLE_TICKS, 16'd3);
      send_tick(ALL_HIGH);
      write_register(CSR_SETTLE_TICKS, CSR_DATA_W'(MAX_SETTLE));
      repeat (12) send_tick(ALL_HIGH);
      write_register(CSR_SETTLE_TICKS, 16'd3);
      send_tick(ALL_HIGH);
      finish_entry();

      // random part: several settle times and pins, entries mixed with noise
      random_end = ticks_sent + 1050;
      phase_no = 0;
      while (ticks_sent < random_end) begin
         case (phase_no % 6)
            0: write_register(CSR_SETTLE_TICKS, '0);
            1: write_register(CSR_SETTLE_TICKS, 16'd1);
            2: write_register(CSR_SETTLE_TICKS, CSR_DATA_W'($urandom_range(2, 5)));
            3: write_register(CSR_SETTLE_TICKS, '0);
            4: write_register(CSR_SETTLE_TICKS, 16'd17);
            default: write_register(CSR_SETTLE_TICKS, 16'd3);
         endcase
         case (phase_no % 4)
            0: pin = $urandom_range(0, 9999);
            1: pin = 9999;
            2: pin = $urandom_range(10000, 16383);
            default: pin = 0;
         endcase
         write_register(CSR_PIN_CODE, {2'($urandom_range(0, 3)), CODE_W'(pin)});
         if ($urandom_range(0, 1))
            write_register($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B,
                           CSR_DATA_W'($urandom_range(0, 65535)));
         steady_stretch = (phase_no % 6 == 1);
         phase_end = ticks_sent + 220;
         while (ticks_sent < phase_end && ticks_sent < random_end) begin
            if ($urandom_range(0, 99) < 75) key_in_entry(pin, pin <= 9999 && $urandom_range(0, 1));
            else noise_burst();
         end
         steady_stretch = 1'b0;
         phase_no++;
      end

      drain_requests();
      repeat (20) @(negedge clock);
      $display("run covered %0d column samples, %0d digits, %0d entries (%0d matching)",
               ticks_sent, digits_seen, entries_seen, matches_seen);
      $display("settle times 0 to %0d, pins 0, 9999, above 9999, spare indexes; %0d mismatches",
               MAX_SETTLE, mismatches);
      if (mismatches == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #8000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
